/* rtl/core/ps2_mouse_packet_decoder_unit_assert.svh */
// Assertion macros for the mouse packet decoder.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define PMD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PMD_ASSERT_SAME(lbl, ante, cons, msg)

`define PMD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/ps2md_pkg.sv */
package ps2md_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_MOTION = 8'd1;

    localparam logic [1:0] KIND_MOTION  = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    localparam int unsigned SYNC_BIT    = 3;
    localparam int unsigned XSIGN_BIT   = 4;
    localparam int unsigned YSIGN_BIT   = 5;
    localparam int unsigned ZSIGN_BIT   = 7;
    localparam logic [7:0]  DROP_MASK   = 8'hC0;
    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned DELTA_W     = 10;
    localparam int unsigned OUT_AMT_W   = 16;

    localparam int unsigned EV_X  = 0;
    localparam int unsigned EV_Y  = 1;
    localparam int unsigned EV_Z  = 2;
    localparam int unsigned EV_B0 = 3;
    localparam int unsigned EV_B1 = 4;
    localparam int unsigned EV_B2 = 5;

    typedef logic [5:0] ev_mask_t;
    typedef logic [NUM_BUTTONS-1:0] buttons_t;

endpackage

/* rtl/core/ps2_mouse_packet_decoder_unit.sv */
// Events of an accepted byte are first registered as pending, then loaded one at a time into
// the output registers whenever the output is empty or m_ready is high; a byte causing no
// event takes no output slot, and the next byte is taken as the last event is loaded.
// Reset: synchronous, active low; clears packet position, buttons, accumulators,
// configuration and all pending events. Stored packet bytes are not reset.
`include "ps2_mouse_packet_decoder_unit_assert.svh"

module ps2_mouse_packet_decoder_unit #(
    parameter int unsigned ACC_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2md_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2md_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    input  logic                                s_chunk_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_kind,
    output logic [1:0]                          m_axis_id,
    output logic signed [15:0]                  m_motion_amount,
    output logic [1:0]                          m_button_id,
    output logic                                m_last_event
);

    localparam int unsigned EXT_W = (ACC_WIDTH > 16) ? ACC_WIDTH : 16;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0]          a,
        input logic signed [ps2md_pkg::DELTA_W-1:0] d
    );
        logic signed [ACC_WIDTH:0] s;
        s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(d);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [15:0] low16(input logic signed [ACC_WIDTH-1:0] a);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(a);
        return e[15:0];
    endfunction

    logic                          wheel_reg;
    logic                          compress_reg;
    logic [1:0]                    pos_reg, pos_next;
    logic [7:0]                    pkt0_reg, pkt0_next;
    logic [7:0]                    pkt1_reg, pkt1_next;
    logic [7:0]                    pkt2_reg, pkt2_next;
    ps2md_pkg::buttons_t           prev_reg, prev_next;
    logic signed [ACC_WIDTH-1:0]   accx_reg, accx_next;
    logic signed [ACC_WIDTH-1:0]   accy_reg, accy_next;
    logic signed [ACC_WIDTH-1:0]   accz_reg, accz_next;

    ps2md_pkg::ev_mask_t           pend_reg, pend_next, new_mask;
    logic signed [15:0]            amtx_reg, amtx_next;
    logic signed [15:0]            amty_reg, amty_next;
    logic signed [15:0]            amtz_reg, amtz_next;
    ps2md_pkg::buttons_t           btn_reg, btn_next;

    logic                          m_valid_reg;
    logic [1:0]                    kind_reg, kind_next;
    logic [1:0]                    axis_reg, axis_next;
    logic signed [15:0]            amt_reg, amt_next;
    logic [1:0]                    bid_reg, bid_next;
    logic                          last_reg, last_next;

    logic                          in_acc;
    logic                          out_adv;
    ps2md_pkg::ev_mask_t           sel;
    ps2md_pkg::ev_mask_t           rest;

    logic                          complete;
    logic                          take_first;
    logic                          good;
    logic                          flush;
    logic [7:0]                    p2;
    ps2md_pkg::buttons_t           buttons;
    ps2md_pkg::buttons_t           changed;
    logic signed [ps2md_pkg::DELTA_W-1:0] dx, dy, dz;
    logic signed [ACC_WIDTH-1:0]   sumx, sumy, sumz;

    assign cfg_ready = 1'b1;

    assign out_adv = !m_valid_reg || m_ready;
    assign sel     = pend_reg & (~pend_reg + 6'd1);
    assign rest    = pend_reg & ~sel;
    assign s_ready = (pend_reg == '0) || (out_adv && (rest == '0));
    assign in_acc  = s_valid && s_ready;

    assign complete = wheel_reg ? (pos_reg == 2'd3) : (pos_reg >= 2'd2);
    assign p2       = wheel_reg ? pkt2_reg : s_rx_byte;
    assign buttons  = pkt0_reg[ps2md_pkg::NUM_BUTTONS-1:0];
    assign changed  = buttons ^ prev_reg;

    assign dx = ps2md_pkg::DELTA_W'($signed({pkt0_reg[ps2md_pkg::XSIGN_BIT], pkt1_reg}));
    assign dy = -ps2md_pkg::DELTA_W'($signed({pkt0_reg[ps2md_pkg::YSIGN_BIT], p2}));
    assign dz = wheel_reg
              ? ps2md_pkg::DELTA_W'($signed({s_rx_byte[ps2md_pkg::ZSIGN_BIT], s_rx_byte[3:0]}))
              : '0;

    assign sumx = sat_add(accx_reg, dx);
    assign sumy = sat_add(accy_reg, dy);
    assign sumz = sat_add(accz_reg, dz);

    always_comb begin
        pos_next   = pos_reg;
        pkt0_next  = pkt0_reg;
        pkt1_next  = pkt1_reg;
        pkt2_next  = pkt2_reg;
        prev_next  = prev_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        accz_next  = accz_reg;
        amtx_next  = amtx_reg;
        amty_next  = amty_reg;
        amtz_next  = amtz_reg;
        btn_next   = buttons;
        new_mask   = '0;
        take_first = 1'b0;
        good       = 1'b0;

        if (pos_reg == 2'd0) begin
            take_first = 1'b1;
        end else if (!complete) begin
            if (pos_reg == 2'd1) begin
                pkt1_next = s_rx_byte;
            end else begin
                pkt2_next = s_rx_byte;
            end
            pos_next = pos_reg + 2'd1;
        end else begin
            pos_next = 2'd0;
            if (!pkt0_reg[ps2md_pkg::SYNC_BIT]) begin
                take_first = 1'b1;
            end else begin
                good = 1'b1;
            end
        end

        if (take_first) begin
            if ((s_rx_byte & ps2md_pkg::DROP_MASK) == 8'd0) begin
                pkt0_next = s_rx_byte;
                pos_next  = 2'd1;
            end else begin
                pos_next  = 2'd0;
            end
        end

        if (good) begin
            accx_next = sumx;
            accy_next = sumy;
            accz_next = sumz;
            prev_next = buttons;
            new_mask[ps2md_pkg::EV_B2:ps2md_pkg::EV_B0] = changed;
        end

        flush = (good && (!compress_reg || (changed != '0))) || s_chunk_end;

        if (flush) begin
            new_mask[ps2md_pkg::EV_X] = (accx_next != '0);
            new_mask[ps2md_pkg::EV_Y] = (accy_next != '0);
            new_mask[ps2md_pkg::EV_Z] = (accz_next != '0);
            amtx_next = low16(accx_next);
            amty_next = low16(accy_next);
            amtz_next = low16(accz_next);
            accx_next = '0;
            accy_next = '0;
            accz_next = '0;
        end
    end

    always_comb begin
        kind_next = ps2md_pkg::KIND_MOTION;
        axis_next = ps2md_pkg::AXIS_X;
        amt_next  = '0;
        bid_next  = ps2md_pkg::BTN_LEFT;
        last_next = (rest == '0);
        priority if (pend_reg[ps2md_pkg::EV_X]) begin
            amt_next  = amtx_reg;
        end else if (pend_reg[ps2md_pkg::EV_Y]) begin
            axis_next = ps2md_pkg::AXIS_Y;
            amt_next  = amty_reg;
        end else if (pend_reg[ps2md_pkg::EV_Z]) begin
            axis_next = ps2md_pkg::AXIS_Z;
            amt_next  = amtz_reg;
        end else if (pend_reg[ps2md_pkg::EV_B0]) begin
            kind_next = btn_reg[0] ? ps2md_pkg::KIND_PRESS : ps2md_pkg::KIND_RELEASE;
        end else if (pend_reg[ps2md_pkg::EV_B1]) begin
            kind_next = btn_reg[1] ? ps2md_pkg::KIND_PRESS : ps2md_pkg::KIND_RELEASE;
            bid_next  = ps2md_pkg::BTN_RIGHT;
        end else if (pend_reg[ps2md_pkg::EV_B2]) begin
            kind_next = btn_reg[2] ? ps2md_pkg::KIND_PRESS : ps2md_pkg::KIND_RELEASE;
            bid_next  = ps2md_pkg::BTN_MIDDLE;
        end else begin
            last_next = 1'b0;
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (out_adv) begin
            pend_next = rest;
        end
        if (in_acc) begin
            pend_next = new_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_reg    <= 1'b0;
            compress_reg <= 1'b0;
            pos_reg      <= 2'd0;
            prev_reg     <= '0;
            accx_reg     <= '0;
            accy_reg     <= '0;
            accz_reg     <= '0;
            pend_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ps2md_pkg::REG_WHEEL_MODE) begin
                    wheel_reg <= cfg_data[0];
                end else if (cfg_index == ps2md_pkg::REG_COMPRESS_MOTION) begin
                    compress_reg <= cfg_data[0];
                end
            end
            if (in_acc) begin
                pos_reg  <= pos_next;
                prev_reg <= prev_next;
                accx_reg <= accx_next;
                accy_reg <= accy_next;
                accz_reg <= accz_next;
            end
            pend_reg <= pend_next;
            if (out_adv) begin
                m_valid_reg <= (pend_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pkt0_reg <= pkt0_next;
            pkt1_reg <= pkt1_next;
            pkt2_reg <= pkt2_next;
            amtx_reg <= amtx_next;
            amty_reg <= amty_next;
            amtz_reg <= amtz_next;
            btn_reg  <= btn_next;
        end
        if (out_adv) begin
            kind_reg <= kind_next;
            axis_reg <= axis_next;
            amt_reg  <= amt_next;
            bid_reg  <= bid_next;
            last_reg <= last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = kind_reg;
    assign m_axis_id       = axis_reg;
    assign m_motion_amount = amt_reg;
    assign m_button_id     = bid_reg;
    assign m_last_event    = last_reg;

    `PMD_ASSERT_NEXT(a_pend_moves_out, (pend_reg != '0) && !m_valid_reg, m_valid_reg,
        "pending event not presented")
    `PMD_ASSERT_NEXT(a_chunk_flush, in_acc && s_chunk_end,
        (accx_reg == '0) && (accy_reg == '0) && (accz_reg == '0),
        "accumulators not cleared at chunk end")
    `PMD_ASSERT_NEXT(a_drop_unsynced,
        in_acc && (pos_reg == 2'd0) && ((s_rx_byte & ps2md_pkg::DROP_MASK) != 8'd0),
        pos_reg == 2'd0, "bad first byte started a packet")
    `PMD_ASSERT_SAME(a_button_fields, m_valid_reg && (kind_reg != ps2md_pkg::KIND_MOTION),
        (amt_reg == '0) && (axis_reg == ps2md_pkg::AXIS_X),
        "button event carries motion fields")

endmodule
